### rtl/fir23_pkg.sv
package fir23_pkg;

  // Number of distinct coefficients in the half table (last one is the center tap)
  localparam int HALF_N = 12;
  localparam int HIDX_W = 4;

  localparam logic signed [15:0] HALF_COEF [HALF_N] = '{
    -16'sd114,  -16'sd814,  -16'sd1532, -16'sd1255, 16'sd336,   16'sd1591,
    16'sd498,   -16'sd2137, -16'sd2366, 16'sd2580,  16'sd10030, 16'sd13636
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WR,
    ST_WAIT,
    ST_OUT
  } fir23_state_e;

  // Per-tap control beat from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last;
    logic signed [15:0] coef;
  } fir23_mac_ctl_t;

  // Symmetric coefficient of tap i: mirror around the center, cap at the center value
  function automatic logic signed [15:0] coef_at(input int i, input int taps);
    int k;
    int m;
    k = i;
    m = taps - 1 - i;
    if (m < k) k = m;
    if (k < 0) k = 0;
    if (k > HALF_N - 1) k = HALF_N - 1;
    return HALF_COEF[k[HIDX_W-1:0]];
  endfunction

endpackage

### rtl/fir_filter_23_tap.sv
// Symmetric direct-form FIR filter on signed 16-bit samples. One sample is
// taken per beat and gives one filtered sample: the new sample and the TAPS-1
// previous ones are weighted by fixed symmetric coefficients, summed exactly,
// shifted right arithmetically by OUT_SHIFT and wrapped to 16 bits. The delay
// line sits in a circular buffer memory with one read port; one tap is read
// and multiplied per cycle, a rate set by that single read port and the one
// multiplier. The next sample is accepted as soon as the sequencer is idle,
// even while the previous result still waits in the output register. The
// delay line reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed.
module fir_filter_23_tap
  import fir23_pkg::*;
#(
  parameter int TAPS      = 23,
  parameter int OUT_SHIFT = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o
);

  localparam int DEPTH = TAPS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(TAPS);
  localparam int ACC_W = 32 + $clog2(TAPS) + 1;

  fir23_state_e            state_q, state_d;
  logic [TW-1:0]           tap_q, tap_d;
  logic [AW-1:0]           rp_q, rp_d;
  logic [AW-1:0]           wp_q, wp_d;
  logic signed [15:0]      x_q;
  fir23_mac_ctl_t          ctl_d, ctl_q;
  logic                    rd_en;
  logic                    wr_en;
  logic signed [15:0]      rd_data;
  logic                    rd_vld;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;
  logic                    out_load;
  logic                    out_valid_q;
  logic signed [15:0]      out_q;
  logic signed [ACC_W-1:0] acc_sh;
  logic                    in_fire;
  logic                    last_tap;

  assign in_fire  = in_valid_i && in_ready_o;
  assign last_tap = (tap_q == TW'(TAPS - 1));
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (last_tap) state_d = ST_WR;
      ST_WR:   state_d = ST_WAIT;
      ST_WAIT: if (mac_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: tap issue, memory access, pointers
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    tap_d      = tap_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    ctl_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        tap_d      = '0;
        rp_d       = (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - 1'b1;
      end
      ST_RUN: begin
        ctl_d.vld   = 1'b1;
        ctl_d.first = (tap_q == '0);
        ctl_d.last  = last_tap;
        ctl_d.coef  = coef_at(int'(tap_q), TAPS);
        if (tap_q != '0) begin
          rd_en = 1'b1;
          rp_d  = (rp_q == '0) ? AW'(DEPTH - 1) : rp_q - 1'b1;
        end
        if (!last_tap) begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_WR: begin
        // Overwrite the oldest entry with the new sample
        wr_en = 1'b1;
        wp_d  = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      ST_WAIT, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      rp_q    <= '0;
      wp_q    <= '0;
      ctl_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      ctl_q   <= ctl_d;
    end
  end

  // Hold the accepted sample for the whole pass
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= sample_in_i;
    end
  end

  fir23_dly_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rp_q),
    .rd_data_o (rd_data),
    .rd_vld_o  (rd_vld),
    .wr_en_i   (wr_en),
    .wr_addr_i (wp_q),
    .wr_data_i (x_q)
  );

  fir23_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_q),
    .x_i       (x_q),
    .rd_data_i (rd_data),
    .rd_vld_i  (rd_vld),
    .acc_o     (acc),
    .done_o    (mac_done)
  );

  // Scale and wrap the sum into the output register
  assign acc_sh = acc >>> OUT_SHIFT;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= acc_sh[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

`ifndef SYNTHESIS
  a_no_rd_wr_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("delay line read and write in the same cycle");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_WAIT))
    else $error("accumulator finished outside the wait state");

  a_accept_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN) && (tap_q == '0))
    else $error("accepted sample did not start a pass at the first tap");
`endif

endmodule

### rtl/fir23_dly_mem.sv
module fir23_dly_mem
  import fir23_pkg::*;
#(
  parameter int DEPTH = 22,
  parameter int AW    = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic signed [15:0]   rd_data_o,
  output logic                 rd_vld_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic signed [15:0]   wr_data_i
);

  logic signed [15:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic signed [15:0] rd_data_q;
  logic               rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Track written entries; a read of an unwritten entry returns with the valid flag low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

### rtl/fir23_mac.sv
module fir23_mac
  import fir23_pkg::*;
#(
  parameter int ACC_W = 38
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fir23_mac_ctl_t          ctl_i,
  input  logic signed [15:0]      x_i,
  input  logic signed [15:0]      rd_data_i,
  input  logic                    rd_vld_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);

  logic signed [15:0]      op;
  logic signed [31:0]      prod_d, prod_q;
  logic                    pvld_q, pfirst_q, plast_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic                    done_q;

  // Pick the tap operand: new sample for the first tap, else the delay line word
  always_comb begin
    if (ctl_i.first) begin
      op = x_i;
    end else if (rd_vld_i) begin
      op = rd_data_i;
    end else begin
      op = '0;
    end
    prod_d = op * ctl_i.coef;
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q   <= 1'b0;
      pfirst_q <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      pvld_q   <= ctl_i.vld;
      pfirst_q <= ctl_i.first;
      plast_q  <= ctl_i.last;
      done_q   <= pvld_q & plast_q;
    end
  end

  // Accumulate; restart on the first tap
  always_comb begin
    acc_d = acc_q;
    if (pvld_q) begin
      if (pfirst_q) begin
        acc_d = ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule
